@@ rtl/skrfi_pkg.sv @@
// skrfi_pkg: shared constants, register codes and types for the SK RFI mask unit.
// No dependencies; imported by the interfaces and every rtl module.
`default_nettype none
package skrfi_pkg;

   // Channel and integration geometry
   localparam int CHAN_COUNT     = 256;
   localparam int FREQ_W         = $clog2(CHAN_COUNT);
   localparam int MAX_THRESHOLDS = 4;
   localparam int MAX_SAMPLES    = 256;
   localparam int LEN_W          = $clog2(MAX_SAMPLES) + 1;  // holds 1..MAX_SAMPLES
   localparam int CNT_W          = $clog2(MAX_SAMPLES) + 1;  // counts reach MAX_SAMPLES
   localparam int POS_W          = CNT_W;

   // Sample and table field widths
   localparam int SK_W   = 16;
   localparam int SLOT_W = 16;
   localparam int PROD_W = SLOT_W + SK_W + 1;   // signed threshold x unsigned sigma
   localparam int CMP_W  = PROD_W + 2;          // room for the +1.0 offset

   // 1.0 in Q.20, the offset added to threshold*sigma
   localparam logic signed [CMP_W-1:0] ONE_Q20 = CMP_W'(1 << 20);

   // Configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   typedef enum logic [2:0] {
      REG_EXCISION_ENABLED = 3'd0,
      REG_ACTIVE_COUNT     = 3'd1,
      REG_SAMPLES_PER_INT  = 3'd2,
      REG_THRESHOLD_TABLE  = 3'd3,
      REG_LIMIT_TABLE      = 3'd4
   } csr_reg_type;

   // Normalized configuration handed to the datapath
   typedef struct packed {
      logic                                  excision_enabled;
      logic [2:0]                            active_count;   // 0..MAX_THRESHOLDS
      logic [LEN_W-1:0]                      int_len;        // 1..MAX_SAMPLES
      logic [MAX_THRESHOLDS-1:0][SLOT_W-1:0] thr;
      logic [MAX_THRESHOLDS-1:0][SLOT_W-1:0] lim;
   } cfg_type;

   // One channel's counters as stored in the memory
   typedef struct packed {
      logic [POS_W-1:0]                     pos;
      logic [MAX_THRESHOLDS-1:0][CNT_W-1:0] cnt;
   } chan_entry_type;

endpackage
`default_nettype wire

@@ rtl/skrfi_if.sv @@
// skrfi_req_if / skrfi_rsp_if: valid/ready channels for SK samples and mask results.
// Depends on skrfi_pkg for field widths.
`default_nettype none
interface skrfi_req_if import skrfi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SK_W-1:0]   sk_value;
   logic [SK_W-1:0]   sk_sigma;
   logic [FREQ_W-1:0] freq_index;

   modport source (output valid, output sk_value, output sk_sigma, output freq_index,
                   input ready);
   modport sink   (input valid, input sk_value, input sk_sigma, input freq_index,
                   output ready);
endinterface

interface skrfi_rsp_if import skrfi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] out_freq_index;
   logic              mask_good;

   modport source (output valid, output out_freq_index, output mask_good, input ready);
   modport sink   (input valid, input out_freq_index, input mask_good, output ready);
endinterface
`default_nettype wire

@@ rtl/skrfi_csr.sv @@
// skrfi_csr: APB-style configuration registers with readback and normalization.
// Depends on skrfi_pkg.
`default_nettype none
module skrfi_csr import skrfi_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic                    enable_ff, enable_in;
   logic [2:0]              active_ff, active_in;
   logic [LEN_W-1:0]        spi_ff, spi_in;
   logic [CSR_DATA_W-1:0]   thr_ff, thr_in;
   logic [CSR_DATA_W-1:0]   lim_ff, lim_in;
   logic                    wr_en;
   csr_reg_type             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);

   // Write decode
   always_comb begin
      enable_in = enable_ff;
      active_in = active_ff;
      spi_in    = spi_ff;
      thr_in    = thr_ff;
      lim_in    = lim_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_EXCISION_ENABLED: enable_in = csr_pwdata[0];
            REG_ACTIVE_COUNT:     active_in = csr_pwdata[2:0];
            REG_SAMPLES_PER_INT:  spi_in    = csr_pwdata[LEN_W-1:0];
            REG_THRESHOLD_TABLE:  thr_in    = csr_pwdata;
            REG_LIMIT_TABLE:      lim_in    = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         active_ff <= '0;
         spi_ff    <= LEN_W'(1);
         thr_ff    <= '0;
         lim_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         active_ff <= active_in;
         spi_ff    <= spi_in;
         thr_ff    <= thr_in;
         lim_ff    <= lim_in;
      end
   end

   // Readback of raw register values
   always_comb begin
      unique case (reg_sel)
         REG_EXCISION_ENABLED: csr_prdata = CSR_DATA_W'(enable_ff);
         REG_ACTIVE_COUNT:     csr_prdata = CSR_DATA_W'(active_ff);
         REG_SAMPLES_PER_INT:  csr_prdata = CSR_DATA_W'(spi_ff);
         REG_THRESHOLD_TABLE:  csr_prdata = thr_ff;
         REG_LIMIT_TABLE:      csr_prdata = lim_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // Normalized view: zero length means one, lengths and slot counts saturate
   always_comb begin
      cfg.excision_enabled = enable_ff;
      cfg.active_count     = (active_ff > 3'(MAX_THRESHOLDS)) ? 3'(MAX_THRESHOLDS) : active_ff;
      if (spi_ff == '0)
         cfg.int_len = LEN_W'(1);
      else if (spi_ff > LEN_W'(MAX_SAMPLES))
         cfg.int_len = LEN_W'(MAX_SAMPLES);
      else
         cfg.int_len = spi_ff;
      cfg.thr = thr_ff;
      cfg.lim = lim_ff;
   end

endmodule
`default_nettype wire

@@ rtl/skrfi_chan_mem.sv @@
// skrfi_chan_mem: per-channel counter store, one write and one registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on skrfi_pkg.
`default_nettype none
module skrfi_chan_mem import skrfi_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [FREQ_W-1:0] rd_addr,
   output chan_entry_type         rd_data,
   input  wire logic              wr_en,
   input  wire logic [FREQ_W-1:0] wr_addr,
   input  chan_entry_type         wr_data
);

   chan_entry_type             entry_ff [CHAN_COUNT];
   logic [CHAN_COUNT-1:0]      valid_ff;
   chan_entry_type             rd_raw_ff;
   logic                       rd_valid_ff;

   // Storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= entry_ff[rd_addr];
      end
   end

   // Valid bits, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule
`default_nettype wire

@@ rtl/sk_rfi_integration_mask_unit.sv @@
// sk_rfi_integration_mask_unit: SK RFI mask over per-channel integrations; uses skrfi_pkg,
// skrfi_if, skrfi_csr and skrfi_chan_mem.
// Path: stage 1, then the result register; a held result can stall stage 1 and accept.
// Throughput: one request per cycle when not stalled; the store is read at accept and written
// when stage 1 fires, with a bypass register covering back-to-back requests on one channel.
// Reset: synchronous; clears pipeline, config and store valid bits.
`default_nettype none
module sk_rfi_integration_mask_unit import skrfi_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   skrfi_req_if.sink                  req_if,
   skrfi_rsp_if.source                rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;

   skrfi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake and stage control
   logic accept;
   logic s1_fire;
   logic s1_last;
   logic out_free;

   // Stage 1 registers
   logic                    s1_valid_ff, s1_valid_in;
   logic [FREQ_W-1:0]       s1_freq_ff;
   logic [SK_W-1:0]         s1_sk_ff;
   logic signed [PROD_W-1:0] s1_prod_ff [MAX_THRESHOLDS];
   logic signed [PROD_W-1:0] prod_in    [MAX_THRESHOLDS];

   // Store access and bypass
   chan_entry_type    mem_rd_data;
   chan_entry_type    cur_entry;
   chan_entry_type    next_entry;
   logic              byp_valid_ff;
   logic [FREQ_W-1:0] byp_addr_ff;
   chan_entry_type    byp_data_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0] rsp_freq_ff;
   logic              rsp_good_ff;
   logic              good;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire      = s1_valid_ff && (!s1_last || out_free);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign accept       = req_if.valid && req_if.ready;

   skrfi_chan_mem u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_if.freq_index),
      .rd_data (mem_rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_freq_ff),
      .wr_data (next_entry)
   );

   // Stage 0: threshold times sigma, one product per slot
   always_comb begin
      for (int k = 0; k < MAX_THRESHOLDS; k++) begin
         prod_in[k] = $signed(cfg.thr[k]) * $signed({1'b0, req_if.sk_sigma});
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_freq_ff <= req_if.freq_index;
         s1_sk_ff   <= req_if.sk_value;
         for (int k = 0; k < MAX_THRESHOLDS; k++) begin
            s1_prod_ff[k] <= prod_in[k];
         end
      end
   end

   // Stage 1: pick the freshest counters; the last write may not be in the read data yet
   assign cur_entry = (byp_valid_ff && (byp_addr_ff == s1_freq_ff)) ? byp_data_ff
                                                                   : mem_rd_data;

   // Stage 1: exceed test, count update, end-of-integration check
   always_comb begin
      logic signed [CMP_W-1:0] lhs;
      logic signed [CMP_W-1:0] rhs;
      logic [CNT_W-1:0]        cnt_upd [MAX_THRESHOLDS];
      lhs     = $signed({{(CMP_W-SK_W-8){1'b0}}, s1_sk_ff, 8'h00});
      s1_last = ({1'b0, cur_entry.pos} + (POS_W+1)'(1)) >= (POS_W+1)'(cfg.int_len);
      good    = 1'b1;
      for (int k = 0; k < MAX_THRESHOLDS; k++) begin
         rhs        = $signed({{(CMP_W-PROD_W){s1_prod_ff[k][PROD_W-1]}}, s1_prod_ff[k]})
                      + ONE_Q20;
         cnt_upd[k] = cur_entry.cnt[k] + CNT_W'(lhs > rhs);
         // slots past the active count are counted but never judged
         if ((3'(k) < cfg.active_count) &&
             ($signed({{(SLOT_W-CNT_W){1'b0}}, cnt_upd[k]}) > $signed(cfg.lim[k]))) begin
            good = 1'b0;
         end
      end
      if (!cfg.excision_enabled) begin
         good = 1'b1;
      end
      if (s1_last) begin
         next_entry = '0;
      end else begin
         next_entry.pos = cur_entry.pos + POS_W'(1);
         for (int k = 0; k < MAX_THRESHOLDS; k++) begin
            next_entry.cnt[k] = cnt_upd[k];
         end
      end
   end

   // Bypass: copy of the most recent store write
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         byp_addr_ff <= s1_freq_ff;
         byp_data_ff <= next_entry;
      end
   end

   // Result register
   assign rsp_valid_in = (s1_fire && s1_last) ? 1'b1
                       : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last) begin
         rsp_freq_ff <= s1_freq_ff;
         rsp_good_ff <= good;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_freq_index = rsp_freq_ff;
   assign rsp_if.mask_good      = rsp_good_ff;

   // A stalled stage 1 must keep new requests out
   a_stall_blocks_accept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |-> !accept)
      else $error("request accepted while stage 1 stalled");

   // Finishing an integration loads the result register with its channel
   a_result_follows_fire: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last) |=> (rsp_valid_ff && (rsp_freq_ff == $past(s1_freq_ff))))
      else $error("finished integration did not reach the result register");

   // Stored position always stays inside the longest integration
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_fire |-> ({1'b0, next_entry.pos} < (POS_W+1)'(MAX_SAMPLES)))
      else $error("channel position out of range");

endmodule
`default_nettype wire
